// ----- hw/rtl/pfr_pkg.sv -----
// pfr_pkg: shared types and constants for the parallel-port frame receiver
// used by pfr_cfg, pfr_front, pfr_queue, pfr_back and the top level; no dependencies
`timescale 1ns / 1ps

package pfr_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam logic [15:0] HEADER_EXTRA = 16'd6;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [7:0]  MAGIC_RESET   = 8'h42;
  localparam logic [7:0]  CRC_ON_RESET  = 8'd1;
  localparam logic [7:0]  CRC_OFF_RESET = 8'd2;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_MAGIC   = 2'd1,
    REG_CRC_ON  = 2'd2,
    REG_CRC_OFF = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_START  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CRCTYPE,
    PH_SIZE,
    PH_CRCW,
    PH_TYPE,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TIMEOUT       = 3'd1,
    ST_INVALID_START = 3'd2,
    ST_NO_MAGIC      = 3'd3,
    ST_BAD_CRC_TYPE  = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  magic_value;
    logic [7:0]  crc_on_code;
    logic [7:0]  crc_off_code;
  } cfg_t;

  // one record per item that produced output; two adds a trailing ok end
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_value;
    logic [7:0]  crc_kind;
    logic [15:0] payload_len;
    logic [15:0] crc_word;
    logic [31:0] frame_type;
    status_e     status;
    logic        busy_level;
    logic        two;
  } rec_t;

endpackage

// ----- hw/rtl/pfr_in_if.sv -----
// pfr_in_if: input channel of the frame receiver, one word per pin event
// depends on nothing
`timescale 1ns / 1ps

interface pfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       line_level;
  logic [7:0] data_in;

  modport source (output valid, req_type, line_level, data_in, input ready);
  modport sink (input valid, req_type, line_level, data_in, output ready);
endinterface

// ----- hw/rtl/pfr_out_if.sv -----
// pfr_out_if: result channel of the frame receiver
// depends on nothing
`timescale 1ns / 1ps

interface pfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [7:0]  crc_kind;
  logic [15:0] payload_len;
  logic [15:0] crc_word;
  logic [31:0] frame_type;
  logic [2:0]  status;
  logic        busy_level;
  logic        last;

  modport source (output valid, kind, byte_value, crc_kind, payload_len, crc_word,
                  frame_type, status, busy_level, last, input ready);
  modport sink (input valid, kind, byte_value, crc_kind, payload_len, crc_word,
                frame_type, status, busy_level, last, output ready);
endinterface

// ----- hw/rtl/pfr_cfg.sv -----
// pfr_cfg: apb register bank for timeout, magic byte and crc type codes
// depends on pfr_pkg
`timescale 1ns / 1ps

module pfr_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pfr_pkg::cfg_t cfg_o
);

  pfr_pkg::cfg_t    cfg_q, cfg_d;
  pfr_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = pfr_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        pfr_pkg::REG_TIMEOUT: cfg_d.timeout_ticks = pwdata[15:0];
        pfr_pkg::REG_MAGIC:   cfg_d.magic_value   = pwdata[7:0];
        pfr_pkg::REG_CRC_ON:  cfg_d.crc_on_code   = pwdata[7:0];
        pfr_pkg::REG_CRC_OFF: cfg_d.crc_off_code  = pwdata[7:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pfr_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_ticks};
      pfr_pkg::REG_MAGIC:   prdata = {24'd0, cfg_q.magic_value};
      pfr_pkg::REG_CRC_ON:  prdata = {24'd0, cfg_q.crc_on_code};
      pfr_pkg::REG_CRC_OFF: prdata = {24'd0, cfg_q.crc_off_code};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= pfr_pkg::TIMEOUT_RESET;
      cfg_q.magic_value   <= pfr_pkg::MAGIC_RESET;
      cfg_q.crc_on_code   <= pfr_pkg::CRC_ON_RESET;
      cfg_q.crc_off_code  <= pfr_pkg::CRC_OFF_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hw/rtl/pfr_front.sv -----
// pfr_front: accepts pin event words, runs the handshake and header state
// machine and pushes result records; depends on pfr_pkg and pfr_in_if
`timescale 1ns / 1ps

module pfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfr_pkg::cfg_t cfg_i,
  pfr_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output pfr_pkg::rec_t rec_o
);

  typedef struct packed {
    logic              start_ok;
    logic              tick;
    logic              take;
    logic              fin;
    pfr_pkg::status_e  fin_st;
    logic              begin_hdr;
    logic              pay_byte;
  } dec_t;

  pfr_pkg::phase_e phase_q, phase_d;
  logic            exp_q, exp_d;
  logic [15:0]     timer_q, timer_d;
  logic [23:0]     shift_q, shift_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crck_q, crck_d;
  logic [15:0]     left_q, left_d;
  logic            busy_q, busy_d;

  pfr_pkg::req_e req;
  logic          lvl;
  logic [7:0]    din;
  logic          fire;
  logic [15:0]   timer_inc;
  logic [15:0]   hdr_word;
  dec_t          dec;

  assign req       = pfr_pkg::req_e'(in_i.req_type);
  assign lvl       = in_i.line_level;
  assign din       = in_i.data_in;
  assign in_i.ready = ~full_i;
  assign fire      = in_i.valid & ~full_i;
  assign timer_inc = (timer_q != 16'hFFFF) ? timer_q + 16'd1 : timer_q;
  assign hdr_word  = {shift_q[7:0], din};

  always_comb begin
    dec = '0;
    dec.fin_st = pfr_pkg::ST_OK;
    if (phase_q == pfr_pkg::PH_IDLE) begin
      if (req == pfr_pkg::REQ_START) begin
        if (!lvl) begin
          dec.fin    = 1'b1;
          dec.fin_st = pfr_pkg::ST_INVALID_START;
        end else if (cfg_i.timeout_ticks == 16'd0) begin
          dec.fin    = 1'b1;
          dec.fin_st = pfr_pkg::ST_TIMEOUT;
        end else begin
          dec.start_ok = 1'b1;
          if (din != cfg_i.magic_value) begin
            dec.fin    = 1'b1;
            dec.fin_st = pfr_pkg::ST_NO_MAGIC;
          end
        end
      end
    end else begin
      unique case (req)
        pfr_pkg::REQ_TICK: begin
          dec.tick = 1'b1;
          if (timer_inc >= cfg_i.timeout_ticks) begin
            dec.fin    = 1'b1;
            dec.fin_st = pfr_pkg::ST_TIMEOUT;
          end
        end
        pfr_pkg::REQ_SAMPLE: begin
          if (timer_q >= cfg_i.timeout_ticks) begin
            dec.fin    = 1'b1;
            dec.fin_st = pfr_pkg::ST_TIMEOUT;
          end else if (lvl == exp_q) begin
            dec.take = 1'b1;
            unique case (phase_q)
              pfr_pkg::PH_CRCTYPE: begin
                if (din != cfg_i.crc_on_code && din != cfg_i.crc_off_code) begin
                  dec.fin    = 1'b1;
                  dec.fin_st = pfr_pkg::ST_BAD_CRC_TYPE;
                end
              end
              pfr_pkg::PH_TYPE: begin
                if (cnt_q == 2'd3) begin
                  dec.begin_hdr = 1'b1;
                  dec.fin       = (left_q == 16'd0);
                end
              end
              pfr_pkg::PH_PAYLOAD: begin
                dec.pay_byte = 1'b1;
                dec.fin      = (left_q == 16'd1);
              end
              default: dec.take = 1'b1;
            endcase
          end
        end
        default: dec = dec;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    timer_d = timer_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    crck_d  = crck_q;
    left_d  = left_q;
    busy_d  = busy_q;
    if (dec.start_ok) begin
      busy_d  = ~busy_q;
      exp_d   = 1'b0;
      timer_d = 16'd0;
      phase_d = pfr_pkg::PH_CRCTYPE;
    end
    if (dec.tick) begin
      timer_d = timer_inc;
    end
    if (dec.take) begin
      busy_d  = ~busy_q;
      exp_d   = ~exp_q;
      timer_d = 16'd0;
      unique case (phase_q)
        pfr_pkg::PH_CRCTYPE: begin
          crck_d  = din;
          phase_d = pfr_pkg::PH_SIZE;
          cnt_d   = 2'd0;
          shift_d = 24'd0;
        end
        pfr_pkg::PH_SIZE, pfr_pkg::PH_CRCW: begin
          if (cnt_q == 2'd0) begin
            shift_d = {shift_q[15:0], din};
            cnt_d   = 2'd1;
          end else begin
            shift_d = 24'd0;
            cnt_d   = 2'd0;
            if (phase_q == pfr_pkg::PH_SIZE) begin
              left_d  = hdr_word - pfr_pkg::HEADER_EXTRA;
              phase_d = pfr_pkg::PH_CRCW;
            end else begin
              crc_d   = hdr_word;
              phase_d = pfr_pkg::PH_TYPE;
            end
          end
        end
        pfr_pkg::PH_TYPE: begin
          shift_d = {shift_q[15:0], din};
          if (cnt_q != 2'd3) begin
            cnt_d = cnt_q + 2'd1;
          end else begin
            cnt_d   = 2'd0;
            phase_d = pfr_pkg::PH_PAYLOAD;
          end
        end
        pfr_pkg::PH_PAYLOAD: left_d = left_q - 16'd1;
        default: phase_d = phase_q;
      endcase
    end
    if (dec.fin) begin
      busy_d  = 1'b0;
      phase_d = pfr_pkg::PH_IDLE;
      exp_d   = 1'b0;
      timer_d = 16'd0;
      cnt_d   = 2'd0;
    end
  end

  // record out
  always_comb begin
    rec_o            = '0;
    rec_o.busy_level = busy_d;
    push_o           = fire & (dec.fin | dec.begin_hdr | dec.pay_byte);
    if (dec.begin_hdr) begin
      rec_o.kind        = pfr_pkg::KIND_BEGIN;
      rec_o.crc_kind    = crck_q;
      rec_o.payload_len = left_q;
      rec_o.crc_word    = crc_q;
      rec_o.frame_type  = {shift_q, din};
      rec_o.two         = dec.fin;
    end else if (dec.pay_byte) begin
      rec_o.kind       = pfr_pkg::KIND_BYTE;
      rec_o.byte_value = din;
      rec_o.two        = dec.fin;
    end else begin
      rec_o.kind   = pfr_pkg::KIND_END;
      rec_o.status = dec.fin_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pfr_pkg::PH_IDLE;
      exp_q   <= 1'b0;
      timer_q <= 16'd0;
      shift_q <= 24'd0;
      cnt_q   <= 2'd0;
      crc_q   <= 16'd0;
      crck_q  <= 8'd0;
      left_q  <= 16'd0;
      busy_q  <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      crck_q  <= crck_d;
      left_q  <= left_d;
      busy_q  <= busy_d;
    end
  end

endmodule

// ----- hw/rtl/pfr_queue.sv -----
// pfr_queue: short record fifo between the front and back parts
// depends on pfr_pkg
`timescale 1ns / 1ps

module pfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pfr_pkg::rec_t rec_i,
  input  logic          pop_i,
  output pfr_pkg::rec_t rec_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned PtrW = (pfr_pkg::QDEPTH > 1) ? $clog2(pfr_pkg::QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(pfr_pkg::QDEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(pfr_pkg::QDEPTH - 1);

  pfr_pkg::rec_t mem_q [pfr_pkg::QDEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == CntW'(0));
  assign full_o  = (cnt_q == CntW'(pfr_pkg::QDEPTH));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/pfr_back.sv -----
// pfr_back: drains result records into the output register, splitting a
// record with a trailing ok end into two words; depends on pfr_pkg, pfr_out_if
`timescale 1ns / 1ps

module pfr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfr_pkg::rec_t rec_i,
  input  logic          empty_i,
  output logic          pop_o,
  pfr_out_if.source     out_o
);

  pfr_pkg::rec_t res_q, res_d;
  logic          last_q, last_d;
  logic          valid_q, valid_d;
  logic          pend_q, pend_d;
  logic          load;

  assign load  = ~valid_q | out_o.ready;
  assign pop_o = load & ~pend_q & ~empty_i;

  always_comb begin
    res_d   = res_q;
    last_d  = last_q;
    valid_d = valid_q;
    pend_d  = pend_q;
    if (load) begin
      if (pend_q) begin
        res_d        = '0;
        res_d.kind   = pfr_pkg::KIND_END;
        res_d.status = pfr_pkg::ST_OK;
        last_d       = 1'b1;
        valid_d      = 1'b1;
        pend_d       = 1'b0;
      end else if (!empty_i) begin
        res_d   = rec_i;
        last_d  = ~rec_i.two;
        valid_d = 1'b1;
        pend_d  = rec_i.two;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.kind        = res_q.kind;
  assign out_o.byte_value  = res_q.byte_value;
  assign out_o.crc_kind    = res_q.crc_kind;
  assign out_o.payload_len = res_q.payload_len;
  assign out_o.crc_word    = res_q.crc_word;
  assign out_o.frame_type  = res_q.frame_type;
  assign out_o.status      = res_q.status;
  assign out_o.busy_level  = res_q.busy_level;
  assign out_o.last        = last_q;

endmodule

// ----- hw/rtl/plip_frame_receiver.sv -----
// plip_frame_receiver: top level of the parallel-port frame receiver
// depends on pfr_pkg, pfr_in_if, pfr_out_if, pfr_cfg, pfr_front, pfr_queue, pfr_back
//
// in_i carries one word per pin event: timer tick, handshake line sample or
// start strobe, with the line level and the data byte. out_o carries result
// words: frame begin with the header, payload bytes and frame end with status;
// busy_level is the busy line after the event and last marks the final word
// of an event. An event gives zero, one or two words.
// The front part takes one word per cycle while the record queue is not full
// and updates the handshake state as it takes the word; a result word is written
// into the record queue then and later loaded into the output register once out_o can take it.
// out_o moves at most one word per cycle, so an event with two words holds
// the output register for both words in turn; in_i keeps one word per cycle as
// long as out_o is ready and results average no more than one word per cycle.
// A four-entry record queue lets the front keep accepting while out_o stalls;
// in_i.ready drops only when that queue is full.
// Reset returns the state machine to idle with busy low, empties the queue
// and loads the register defaults (timeout 5000, magic 0x42, crc codes 1, 2).
// Registers are written over the apb port at byte addresses 0, 4, 8 and 12.
`timescale 1ns / 1ps

module plip_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  pfr_in_if.sink      in_i,
  pfr_out_if.source   out_o
);

  pfr_pkg::cfg_t cfg;
  pfr_pkg::rec_t push_rec, head_rec;
  logic          push, pop, empty, full;

  pfr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .rec_o  (push_rec)
  );

  pfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .rec_o   (head_rec),
    .empty_o (empty),
    .full_o  (full)
  );

  pfr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (head_rec),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
